// ----- rtl/iwt_pkg.sv -----
// Shared types, codes and sizes for the I/O wait table.
`timescale 1ns / 1ps
`default_nettype none

package iwt_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int COUNT_W       = $clog2(TABLE_ENTRIES + 1);

   localparam int OP_W     = 2;
   localparam int DESC_W   = 10;
   localparam int WAITER_W = 8;
   localparam int TIME_W   = 48;
   localparam int STATUS_W = 3;

   // operation codes
   localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
   localparam logic [OP_W-1:0] OP_EVENT  = 2'd1;
   localparam logic [OP_W-1:0] OP_CANCEL = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_WOKEN     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] ST_CANCELLED = 3'd4;

   // cell moves
   localparam logic [1:0] CELL_HOLD = 2'd0;
   localparam logic [1:0] CELL_PUSH = 2'd1;
   localparam logic [1:0] CELL_POP  = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]     operation;
      logic [DESC_W-1:0]   descriptor;
      logic [WAITER_W-1:0] waiter;
      logic                want_write;
      logic [TIME_W-1:0]   deadline;
      logic [TIME_W-1:0]   now_ms;
      logic                ready_read;
      logic                ready_write;
      logic                error_flag;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [WAITER_W-1:0] woken_waiter;
      logic                by_deadline;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic [DESC_W-1:0]   descriptor;
      logic [WAITER_W-1:0] waiter;
      logic                is_write;
      logic [TIME_W-1:0]   deadline;
   } entry_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       load_tail;
   } cell_ctrl_type;

   typedef struct packed {
      logic                is_cancel;
      logic [DESC_W-1:0]   descriptor;
      logic [WAITER_W-1:0] waiter;
      logic [TIME_W-1:0]   now_ms;
      logic                ready_read;
      logic                ready_write;
      logic                error_flag;
   } probe_type;

endpackage

`default_nettype wire

// ----- rtl/iwt_cell.sv -----
// One table cell: holds one pending wait and tests it against the current request.
`timescale 1ns / 1ps
`default_nettype none

module iwt_cell (
   input  wire                        clock,
   input  wire iwt_pkg::cell_ctrl_type ctrl,
   input  wire iwt_pkg::entry_type    prev_entry,
   input  wire iwt_pkg::entry_type    next_entry,
   input  wire iwt_pkg::entry_type    head_entry,
   input  wire iwt_pkg::probe_type    probe,
   output iwt_pkg::entry_type         entry,
   output logic                       match,
   output logic                       timed
);
   import iwt_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;
   logic      kind_ready;

   always_comb begin
      case (ctrl.mode)
         CELL_PUSH: entry_in = prev_entry;
         CELL_POP:  entry_in = ctrl.load_tail ? head_entry : next_entry;
         default:   entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   // wake test for events, waiter test for cancels
   assign kind_ready = entry_ff.is_write ? probe.ready_write : probe.ready_read;
   assign timed      = (entry_ff.deadline != '0) && (entry_ff.deadline <= probe.now_ms);

   always_comb begin
      if (probe.is_cancel) begin
         match = (entry_ff.waiter == probe.waiter);
      end else begin
         match = timed || ((entry_ff.descriptor == probe.descriptor) &&
                           (kind_ready || probe.error_flag));
      end
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

// ----- rtl/io_wait_table_with_deadlines.sv -----
// Top level of the I/O wait table: request decode, cell chain and result register.
//
//   channel   direction  handshake               beat
//   req_      in         req_valid / req_ready   one add, event or cancel request
//   rsp_      out        rsp_valid / rsp_ready   one result, last marks the final one
//
// An event or a cancel rotates the chain one wait past its head cell per cycle,
// dropping the ones that wake or are cancelled and sending the rest to the tail,
// so the newest-first order is back in place when the pass ends. A request code
// of 3 is taken and dropped. A stalled result register holds the pass at the next
// wait that needs a beat. Reset empties the table at once; the cell contents need
// no clearing.
`timescale 1ns / 1ps
`default_nettype none

module io_wait_table_with_deadlines (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire iwt_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output iwt_pkg::rsp_type      rsp_data
);
   import iwt_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_ADD  = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] steps_ff, steps_in;
   logic               found_ff, found_in;
   req_type            req_ff, req_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   entry_type          cell_q [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] cell_match, cell_timed;
   cell_ctrl_type      cell_ctrl [TABLE_ENTRIES];
   entry_type          new_entry;
   probe_type          probe;

   logic               out_free;
   logic               emit;
   rsp_type            emit_data;
   logic [1:0]         chain_mode;
   logic               keep_head;
   logic               other_match;
   logic               accept;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // hold the request for the whole pass
   assign req_in = accept ? req_data : req_ff;

   assign new_entry.descriptor = req_ff.descriptor;
   assign new_entry.waiter     = req_ff.waiter;
   assign new_entry.is_write   = req_ff.want_write;
   assign new_entry.deadline   = req_ff.deadline;

   assign probe.is_cancel   = (req_ff.operation == OP_CANCEL);
   assign probe.descriptor  = req_ff.descriptor;
   assign probe.waiter      = req_ff.waiter;
   assign probe.now_ms      = req_ff.now_ms;
   assign probe.ready_read  = req_ff.ready_read;
   assign probe.ready_write = req_ff.ready_write;
   assign probe.error_flag  = req_ff.error_flag;

   // any wait behind the head that still wakes; recirculated waits never match
   always_comb begin
      other_match = 1'b0;
      for (int i = 1; i < TABLE_ENTRIES; i++) begin
         if (COUNT_W'(i) < count_ff) begin
            other_match = other_match | cell_match[i];
         end
      end
   end

   // the cell chain: index 0 is the newest wait
   for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      entry_type prev_e, next_e;

      if (g == 0) begin : g_head
         assign prev_e = new_entry;
      end else begin : g_body
         assign prev_e = cell_q[g-1];
      end

      if (g == TABLE_ENTRIES - 1) begin : g_tail
         assign next_e = cell_q[g];
      end else begin : g_mid
         assign next_e = cell_q[g+1];
      end

      assign cell_ctrl[g].mode      = chain_mode;
      assign cell_ctrl[g].load_tail = keep_head && (count_ff == COUNT_W'(g + 1));

      iwt_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl[g]),
         .prev_entry (prev_e),
         .next_entry (next_e),
         .head_entry (cell_q[0]),
         .probe      (probe),
         .entry      (cell_q[g]),
         .match      (cell_match[g]),
         .timed      (cell_timed[g])
      );
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      steps_in   = steps_ff;
      found_in   = found_ff;
      emit       = 1'b0;
      emit_data  = '0;
      chain_mode = CELL_HOLD;
      keep_head  = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_data.operation)
                  OP_ADD: state_in = S_ADD;
                  OP_EVENT, OP_CANCEL: begin
                     state_in = S_SCAN;
                     steps_in = count_ff;
                     found_in = 1'b0;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_ADD: begin
            if (out_free) begin
               emit           = 1'b1;
               emit_data.last = 1'b1;
               if (count_ff == COUNT_W'(TABLE_ENTRIES)) begin
                  emit_data.status = ST_FULL;
               end else begin
                  emit_data.status = ST_ADDED;
                  chain_mode       = CELL_PUSH;
                  count_in         = count_ff + 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            if (steps_ff == '0) begin
               if (found_ff) begin
                  state_in = S_IDLE;
               end else if (out_free) begin
                  emit             = 1'b1;
                  emit_data.status = ST_NOT_FOUND;
                  emit_data.last   = 1'b1;
                  state_in         = S_IDLE;
               end
            end else begin
               // a cancel drops only the first wait of its waiter
               if (cell_match[0] && !(probe.is_cancel && found_ff)) begin
                  if (out_free) begin
                     chain_mode = CELL_POP;
                     steps_in   = steps_ff - 1'b1;
                     count_in   = count_ff - 1'b1;
                     found_in   = 1'b1;
                     emit       = 1'b1;
                     if (probe.is_cancel) begin
                        emit_data.status       = ST_CANCELLED;
                        emit_data.woken_waiter = req_ff.waiter;
                        emit_data.last         = 1'b1;
                     end else begin
                        emit_data.status       = ST_WOKEN;
                        emit_data.woken_waiter = cell_q[0].waiter;
                        emit_data.by_deadline  = cell_timed[0];
                        emit_data.last         = !other_match;
                     end
                  end
               end else begin
                  // recirculate the head to the tail
                  chain_mode = CELL_POP;
                  keep_head  = 1'b1;
                  steps_in   = steps_ff - 1'b1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // result register
   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
   assign rsp_in       = emit ? emit_data : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         steps_ff     <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         steps_ff     <= steps_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(TABLE_ENTRIES))
      else $error("pending count above table size");

   a_steps_bound: assert property (@(posedge clock) disable iff (reset)
      steps_ff <= count_ff)
      else $error("scan steps exceed pending waits");

   a_add_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ADD) && out_free && (count_ff != COUNT_W'(TABLE_ENTRIES))
      |=> count_ff == $past(count_ff) + 1'b1)
      else $error("add did not grow the table");

   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !emit)
      else $error("result raised while idle");

endmodule

`default_nettype wire
